// ----- hdl/great_circle_distance_defines.svh -----
// ----------------------------------------------------------------------------
// great circle distance assertion macros
// shared property forms for the distance pipeline checks
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GCD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GCD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// great circle distance package
// constants, cordic angle table and elaboration helpers
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int unsigned ANGLE_FRAC_BITS_DEF = 22;
  localparam int unsigned CORDIC_STAGES_DEF   = 24;

  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned DIST_W     = 31;

  // cordic gain, q0.30
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  // 2*pi*radius in km, q16, per full turn
  localparam logic [31:0] KM_PER_TURN_Q16 = 32'd2626459649;
  // floor(2^16 / 45), slightly low so one correction step suffices
  localparam logic [10:0] RECIP45_Q16 = 11'd1456;
  localparam logic [5:0]  DIV45       = 6'd45;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // 2^n mod 45
  function automatic logic [5:0] pow2_mod45(input int unsigned n);
    logic [6:0] p;
    p = 7'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p << 1;
      if (p >= 7'(DIV45)) begin
        p = p - 7'(DIV45);
      end
    end
    return p[5:0];
  endfunction

  // multiplicative inverse of an odd number mod 2^32
  function automatic logic [31:0] inv_mod32(input logic [31:0] a);
    logic [31:0] x;
    x = a;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - a * x);
    end
    return x;
  endfunction

endpackage

// ----- hdl/great_circle_distance.sv -----
// ----------------------------------------------------------------------------
// great circle distance
// spherical law of cosines on two lat/lon points, cordic cos and acos
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                        | tuser
//  s_axis   | in  | lat_a[30] lon_a[31] lat_b[30] lon_b[31]   | -
//  m_axis   | out | distance_km[31]                           | arg_clamped
//
//  one transfer per cycle in and out when neither side stalls
//  the pipeline holds the two cordic chains and the 31-step square root,
//  one register per step
//  reset clears the valid bits only
//  a full skid register freezes the whole pipeline; nothing is lost
// ----------------------------------------------------------------------------
`include "great_circle_distance_defines.svh"

module great_circle_distance
  import gcd_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // lat_a, lon_a, lat_b, lon_b, zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // distance_km, zero pad
  output logic [0:0]            m_tuser    // arg_clamped
);

  localparam int unsigned N   = CORDIC_STAGES;
  localparam int unsigned SH  = 29 - ANGLE_FRAC_BITS;
  localparam int unsigned XW  = 34;
  localparam int unsigned DW  = 36;
  localparam int unsigned RW  = 31;
  localparam logic [5:0]  P45 = pow2_mod45(SH);
  localparam logic [31:0] INV45 = inv_mod32(32'(DIV45));
  localparam logic signed [38:0] C_ONE39  = 39'sd1073741824;
  localparam logic signed [38:0] C_MONE39 = -39'sd1073741824;
  localparam logic signed [31:0] C_ONE    = 32'sd1073741824;
  localparam logic signed [31:0] C_MONE   = -32'sd1073741824;

  logic ce;
  logic out_valid, skid_valid;

  assign ce       = !skid_valid;
  assign s_tready = ce;

  // ---------------- input fields
  logic signed [29:0] lat_a, lat_b;
  logic signed [30:0] lon_a, lon_b;
  assign lat_a = s_tdata[29:0];
  assign lon_a = s_tdata[60:30];
  assign lat_b = s_tdata[90:61];
  assign lon_b = s_tdata[121:91];

  // ---------------- angle to binary turns
  logic              a1_valid, a2_valid, a3_valid, a4_valid, a5_valid;
  logic signed [DW-1:0] a1_d [3];
  logic [12:0]       a2_s [3];
  logic [31:0]       a2_ulo [3], a3_ulo [3], a4_ulo [3];
  logic [5:0]        a3_dm [3], a4_rem [3];
  logic [31:0]       a5_t [3];

  logic [14:0] s1 [3];
  logic [23:0] m3 [3];
  logic [12:0] r3 [3];
  logic [10:0] w4 [3];
  logic [21:0] m4 [3];
  logic [10:0] r4 [3];
  logic [31:0] t5 [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      s1[l] = 15'(a1_d[l][11:0]) + 15'(a1_d[l][23:12]) + 15'(a1_d[l][35:24])
              - 15'(a1_d[l][35]);
      m3[l] = 24'(a2_s[l]) * 24'(RECIP45_Q16);
      r3[l] = a2_s[l] - 13'(m3[l][23:16]) * 13'(DIV45);
      w4[l] = 11'(a3_dm[l]) * 11'(P45) + 11'd22;
      m4[l] = 22'(w4[l]) * 22'(RECIP45_Q16);
      r4[l] = w4[l] - 11'(m4[l][21:16]) * 11'(DIV45);
      t5[l] = (a4_ulo[l] - 32'(a4_rem[l])) * INV45;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a1_d[0] <= DW'(lon_a) - DW'(lon_b);
      a1_d[1] <= DW'(lat_a) - DW'(lat_b);
      a1_d[2] <= DW'(lat_a) + DW'(lat_b);
      for (int l = 0; l < 3; l++) begin
        a2_s[l]   <= 13'(s1[l][11:0]) + 13'(s1[l][13:12]);
        a2_ulo[l] <= 32'(a1_d[l] <<< SH) + 32'd22;
        a3_dm[l]  <= (r3[l] >= 13'(DIV45)) ? 6'(r3[l] - 13'(DIV45)) : 6'(r3[l]);
        a3_ulo[l] <= a2_ulo[l];
        a4_rem[l] <= (r4[l] >= 11'(DIV45)) ? 6'(r4[l] - 11'(DIV45)) : 6'(r4[l]);
        a4_ulo[l] <= a3_ulo[l];
        a5_t[l]   <= t5[l];
      end
    end
  end

  // ---------------- cosine cordic, rotation mode
  logic [N:0]           cv;
  logic signed [XW-1:0] cx [N+1][3];
  logic signed [XW-1:0] cy [N+1][3];
  logic signed [XW-1:0] cz [N+1][3];
  logic [2:0]           cf [N+1];

  logic [31:0] pre_sum [3];
  logic [31:0] pre_a [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      pre_sum[l] = a5_t[l] + 32'h4000_0000;
      pre_a[l]   = pre_sum[l][31] ? a5_t[l] + 32'h8000_0000 : a5_t[l];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < 3; l++) begin
        cx[0][l] <= XW'(GAIN_Q30);
        cy[0][l] <= '0;
        cz[0][l] <= XW'(signed'(pre_a[l]));
        cf[0][l] <= pre_sum[l][31];
      end
    end
  end

  for (genvar gi = 0; gi < N; gi++) begin : g_cos
    localparam logic signed [XW-1:0] ATN = XW'(ATAN_TURNS[gi]);
    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      always_ff @(posedge clk) begin
        if (ce) begin
          if (!cz[gi][gl][XW-1]) begin
            cx[gi+1][gl] <= cx[gi][gl] - (cy[gi][gl] >>> gi);
            cy[gi+1][gl] <= cy[gi][gl] + (cx[gi][gl] >>> gi);
            cz[gi+1][gl] <= cz[gi][gl] - ATN;
          end else begin
            cx[gi+1][gl] <= cx[gi][gl] + (cy[gi][gl] >>> gi);
            cy[gi+1][gl] <= cy[gi][gl] - (cx[gi][gl] >>> gi);
            cz[gi+1][gl] <= cz[gi][gl] + ATN;
          end
          cf[gi+1][gl] <= cf[gi][gl];
        end
      end
    end
  end

  // ---------------- combine into acos argument
  logic                 c0_valid, c1_valid, c2_valid, c3_valid;
  logic signed [XW-1:0] c0_q [3];
  logic signed [34:0]   c1_a, c1_b;
  logic signed [XW-1:0] c1_q2, c1_q3;
  logic signed [68:0]   c2_p1, c2_p2;
  logic signed [31:0]   c3_c;
  logic                 c3_clamp;

  logic signed [69:0] c_sum;
  logic signed [38:0] c_raw;
  always_comb begin
    c_sum = 70'(c2_p1) - 70'(c2_p2) + 70'sd1073741824;
    c_raw = 39'(c_sum >>> 31);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < 3; l++) begin
        c0_q[l] <= cf[N][l] ? -cx[N][l] : cx[N][l];
      end
      c1_a  <= 35'sd1073741824 + 35'(c0_q[0]);
      c1_b  <= 35'sd1073741824 - 35'(c0_q[0]);
      c1_q2 <= c0_q[1];
      c1_q3 <= c0_q[2];
      c2_p1 <= c1_a * c1_q2;
      c2_p2 <= c1_b * c1_q3;
      if (c_raw > C_ONE39) begin
        c3_c     <= C_ONE;
        c3_clamp <= 1'b1;
      end else if (c_raw < C_MONE39) begin
        c3_c     <= C_MONE;
        c3_clamp <= 1'b1;
      end else begin
        c3_c     <= 32'(c_raw);
        c3_clamp <= 1'b0;
      end
    end
  end

  // ---------------- sqrt(1 - c^2), one result bit per stage
  logic               q1_valid;
  logic signed [63:0] csq_full;
  logic [60:0]        q1_csq;
  logic signed [31:0] q1_c;
  logic               q1_clamp;

  logic [RW:0]        sv;
  logic [32:0]        srem [RW+1];
  logic [RW-1:0]      sroot [RW+1];
  logic [61:0]        svs [RW+1];
  logic signed [31:0] sc [RW+1];
  logic               sfl [RW+1];

  assign csq_full = c3_c * c3_c;

  always_ff @(posedge clk) begin
    if (ce) begin
      q1_csq   <= csq_full[60:0];
      q1_c     <= c3_c;
      q1_clamp <= c3_clamp;
      srem[0]  <= '0;
      sroot[0] <= '0;
      svs[0]   <= 62'h1000_0000_0000_0000 - 62'(q1_csq);
      sc[0]    <= q1_c;
      sfl[0]   <= q1_clamp;
    end
  end

  for (genvar gk = 0; gk < RW; gk++) begin : g_sqrt
    logic [34:0] remn, trial;
    assign remn  = {srem[gk], svs[gk][61:60]};
    assign trial = {2'b00, sroot[gk], 2'b01};
    always_ff @(posedge clk) begin
      if (ce) begin
        if (remn >= trial) begin
          srem[gk+1]  <= 33'(remn - trial);
          sroot[gk+1] <= {sroot[gk][RW-2:0], 1'b1};
        end else begin
          srem[gk+1]  <= remn[32:0];
          sroot[gk+1] <= {sroot[gk][RW-2:0], 1'b0};
        end
        svs[gk+1] <= svs[gk] << 2;
        sc[gk+1]  <= sc[gk];
        sfl[gk+1] <= sfl[gk];
      end
    end
  end

  // ---------------- acos cordic, vectoring mode
  logic [N:0]           av;
  logic signed [XW-1:0] ax [N+1];
  logic signed [XW-1:0] ay [N+1];
  logic signed [XW-1:0] az [N+1];
  logic                 afl [N+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      if (sc[RW] < 0) begin
        ax[0] <= XW'({1'b0, sroot[RW]});
        ay[0] <= -XW'(sc[RW]);
        az[0] <= XW'(33'sh0_4000_0000);
      end else begin
        ax[0] <= XW'(sc[RW]);
        ay[0] <= XW'({1'b0, sroot[RW]});
        az[0] <= '0;
      end
      afl[0] <= sfl[RW];
    end
  end

  for (genvar gi = 0; gi < N; gi++) begin : g_acos
    localparam logic signed [XW-1:0] ATN = XW'(ATAN_TURNS[gi]);
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!ay[gi][XW-1]) begin
          ax[gi+1] <= ax[gi] + (ay[gi] >>> gi);
          ay[gi+1] <= ay[gi] - (ax[gi] >>> gi);
          az[gi+1] <= az[gi] + ATN;
        end else begin
          ax[gi+1] <= ax[gi] - (ay[gi] >>> gi);
          ay[gi+1] <= ay[gi] + (ax[gi] >>> gi);
          az[gi+1] <= az[gi] - ATN;
        end
        afl[gi+1] <= afl[gi];
      end
    end
  end

  // ---------------- clamp angle and scale to km
  logic        cl_valid, d1_valid, d2_valid;
  logic [31:0] cl_z;
  logic        cl_flag, d1_flag, d2_flag;
  logic [63:0] d1_prod;
  logic [63:0] km_prod;
  logic [63:0] km_round;
  logic [DIST_W-1:0] d2_dist;

  assign km_prod  = 64'(cl_z) * 64'(KM_PER_TURN_Q16);
  assign km_round = d1_prod + 64'h8000_0000;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (az[N] < 0) begin
        cl_z <= '0;
      end else if (az[N] > XW'(33'sh0_8000_0000)) begin
        cl_z <= 32'h8000_0000;
      end else begin
        cl_z <= az[N][31:0];
      end
      cl_flag <= afl[N];
      d1_prod <= km_prod;
      d1_flag <= cl_flag;
      d2_dist <= km_round[62:32];
      d2_flag <= d1_flag;
    end
  end

  // ---------------- valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a1_valid <= 1'b0;
      a2_valid <= 1'b0;
      a3_valid <= 1'b0;
      a4_valid <= 1'b0;
      a5_valid <= 1'b0;
      cv       <= '0;
      c0_valid <= 1'b0;
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
      c3_valid <= 1'b0;
      q1_valid <= 1'b0;
      sv       <= '0;
      av       <= '0;
      cl_valid <= 1'b0;
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
    end else if (ce) begin
      a1_valid <= s_tvalid;
      a2_valid <= a1_valid;
      a3_valid <= a2_valid;
      a4_valid <= a3_valid;
      a5_valid <= a4_valid;
      cv       <= {cv[N-1:0], a5_valid};
      c0_valid <= cv[N];
      c1_valid <= c0_valid;
      c2_valid <= c1_valid;
      c3_valid <= c2_valid;
      q1_valid <= c3_valid;
      sv       <= {sv[RW-1:0], q1_valid};
      av       <= {av[N-1:0], sv[RW]};
      cl_valid <= av[N];
      d1_valid <= cl_valid;
      d2_valid <= d1_valid;
    end
  end

  // ---------------- output register and skid
  logic              push, pop;
  logic [DIST_W-1:0] out_dist, skid_dist;
  logic              out_flag, skid_flag;

  assign push = ce && d2_valid;
  assign pop  = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_dist <= skid_dist;
        out_flag <= skid_flag;
      end else begin
        out_dist <= d2_dist;
        out_flag <= d2_flag;
      end
    end else if (push) begin
      skid_dist <= d2_dist;
      skid_flag <= d2_flag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_dist};
  assign m_tuser  = out_flag;

  // ---------------- checks
  `GCD_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
    "skid register holds an item while output register is empty")
  `GCD_ASSERT_NEXT(a_stall_to_skid, out_valid && !m_tready && push, skid_valid,
    "stalled transfer did not land in skid register")
  `GCD_ASSERT_NEXT(a_freeze, !ce, $stable(d2_valid) && $stable(d2_dist),
    "last stage changed during stall")
  `GCD_ASSERT_NOW(a_clamp_bound, c3_valid && c3_clamp, c3_c == C_ONE || c3_c == C_MONE,
    "clamp flag set with argument not at a bound")

endmodule
